### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sorted key index table.
// Each macro expects clk and the active-low reset rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/skit_pkg.sv
// Shared types and constants for the sorted key index table.
// No dependencies; imported by skit_cmp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package skit_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 256;

    // Fixed field widths
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    // Command codes
    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

    // One table entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    // Result of the shared key comparator
    typedef struct packed {
        logic ge;
        logic eq;
    } cmp_res_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/core/skit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module skit_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/skit_cmp.sv
// Shared key comparator used on every scan step.
// Depends on skit_pkg for the key width and result struct.
`timescale 1ns / 1ps
`default_nettype none

module skit_cmp (
    input  wire logic [skit_pkg::KEY_W-1:0] stored_key,
    input  wire logic [skit_pkg::KEY_W-1:0] probe_key,
    output skit_pkg::cmp_res_t              res
);
    import skit_pkg::*;

    // Unsigned compare of the stored key against the probe
    always_comb
    begin
        res.ge = (stored_key >= probe_key);
        res.eq = (stored_key == probe_key);
    end

endmodule

`default_nettype wire

### rtl/core/sorted_key_index_table.sv
// Top level of the sorted key index table: sequencer, entry memory, comparator.
// Depends on skit_pkg, skit_ram, skit_cmp and assert_macros.svh.
//
//   channel | handshake            | word fields
//   --------+----------------------+---------------------------
//   cmd     | cmd_valid/cmd_ready  | command, key
//   rsp     | rsp_valid/rsp_ready  | status, slot, entry_count
//
// The scan reads one entry a cycle up to the first key not below the probe, and
// an add then moves each larger entry up one place a cycle over the same read
// and write ports; only the entry at the insert position is read twice.
// Reset clears the entry count but not the entries; no clearing pass, entries above the count
// are never read. The response register holds a result while the next command
// is taken; a stalled response only holds the sequencer in its final state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_key_index_table #(
    parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic                             command,
    input  wire logic [skit_pkg::KEY_W-1:0]       key,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic      [skit_pkg::STATUS_W-1:0]    status,
    output logic      [skit_pkg::SLOT_W-1:0]      slot,
    output logic      [skit_pkg::COUNT_OUT_W-1:0] entry_count
);
    import skit_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             chk_reg, chk_next;
    logic             rsp_valid_reg;

    // Working registers
    logic              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;

    // Response register
    logic [STATUS_W-1:0]    status_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [COUNT_OUT_W-1:0] ecount_reg;

    // Memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    cmp_res_t cmp_res;

    // Shared decisions
    logic             scan_found;
    logic             scan_end;
    logic             shift_more;
    logic             can_add;
    logic             rsp_free;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;

    skit_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skit_cmp u_cmp (
        .stored_key (ram_rdata.key),
        .probe_key  (key_reg),
        .res        (cmp_res)
    );

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign scan_found = chk_reg && cmp_res.ge;
    assign scan_end   = !scan_found && (idx_reg == count_reg);
    assign shift_more = (idx_reg > pos_reg);
    assign can_add    = (cmd_reg == CMD_ADD) && !hit_reg && (count_reg < CAP_CNT);
    assign rsp_free   = !rsp_valid_reg || rsp_ready;

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign entry_count = ecount_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_found || scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = can_add ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT:
            begin
                if (!shift_more && !chk_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls per state
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        fslot_next      = fslot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        count_next      = count_reg;
        chk_next        = chk_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Capture the command word
                if (cmd_valid)
                begin
                    cmd_next = command;
                    key_next = key;
                    idx_next = '0;
                    chk_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Stop at the first key not below the probe or at the entry count, else read on
                if (scan_found)
                begin
                    pos_next   = idx_dec;
                    hit_next   = cmp_res.eq;
                    fslot_next = ram_rdata.slot;
                    chk_next   = 1'b0;
                end
                else if (scan_end)
                begin
                    pos_next = count_reg;
                    hit_next = 1'b0;
                    chk_next = 1'b0;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_inc;
                    chk_next  = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                // Settle the status and prepare the shift from the top
                idx_next = count_reg;
                chk_next = 1'b0;
                if (cmd_reg == CMD_FIND)
                begin
                    res_status_next = hit_reg ? STATUS_OK : STATUS_MISS;
                    res_slot_next   = hit_reg ? fslot_reg : '0;
                end
                else if (hit_reg)
                begin
                    res_status_next = STATUS_DUP;
                    res_slot_next   = '0;
                end
                else if (!can_add)
                begin
                    res_status_next = STATUS_FULL;
                    res_slot_next   = '0;
                end
                else
                begin
                    res_status_next = STATUS_OK;
                    res_slot_next   = SLOT_W'(count_reg);
                end
            end
            ST_SHIFT:
            begin
                // Write back the entry read last cycle one place up
                if (chk_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_inc[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (shift_more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[ADDR_W-1:0];
                    idx_next  = idx_dec;
                    chk_next  = 1'b1;
                end
                else if (chk_reg)
                begin
                    chk_next = 1'b0;
                end
                else
                begin
                    // Insert the new entry and advance the count
                    ram_we         = 1'b1;
                    ram_waddr      = pos_reg[ADDR_W-1:0];
                    ram_wdata.key  = key_reg;
                    ram_wdata.slot = res_slot_reg;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                chk_next = 1'b0;
            end
            default:
            begin
                chk_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working and response registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        hit_reg        <= hit_next;
        fslot_reg      <= fslot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            status_reg <= res_status_reg;
            slot_reg   <= res_slot_reg;
            ecount_reg <= COUNT_OUT_W'(count_reg);
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CAP_CNT, "entry count above capacity")
    `ASSERT_IMPLIES(a_count_step, count_reg != $past(count_reg),
        count_reg == CNT_W'($past(count_reg) + 1'b1), "entry count moved by other than one")
    `ASSERT_IMPLIES(a_shift_above_pos, state_reg == ST_SHIFT, pos_reg <= idx_reg,
        "shift index fell below insert position")
    `ASSERT_IMPLIES(a_fail_slot_zero, rsp_valid_reg && (status_reg != STATUS_OK),
        slot_reg == '0, "failed command returned a nonzero slot")

endmodule

`default_nettype wire
